/* rtl/aqs_pkg.sv */
// Package with shared types and constants of the actor queue scheduler.
`timescale 1ns / 1ps
package aqs_pkg;

   localparam int ActorCount   = 64;
   localparam int QueueDepth   = 16;
   localparam int PayloadBits  = 32;
   localparam int KindBits     = 2;
   localparam int IdBits       = 6;
   localparam int MessageBits  = 32;

   // Operation codes of an input item.
   typedef enum logic [KindBits-1:0] {
      KIND_PUSH  = 2'd0,
      KIND_FETCH = 2'd1,
      KIND_POP   = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   // Classified command passed from the front part to the back part.
   typedef struct packed {
      kind_type             kind;
      logic [IdBits-1:0]    actor_id;
      logic                 in_range;
      logic                 held;
      logic [PayloadBits-1:0] payload;
   } cmd_type;

   // Result of one item.
   typedef struct packed {
      logic                 grant_valid;
      logic [IdBits-1:0]    grant_actor;
      logic [MessageBits-1:0] message;
      logic                 message_valid;
      logic                 error;
   } result_type;

endpackage

/* rtl/actor_queue_scheduler_unit.sv */
// Top level of the actor queue scheduler.
// A push or pop passes the READ, EXEC and OUT states before its result is valid.
// A fetch passes READ, EXEC, CHECK, then RING, READ, EXEC, CHECK for each list entry popped.
// The back sequencer takes a new item only when idle with its result hold empty.
// A two-entry queue decouples the input channel from the sequencer.
// Synchronous active-high reset clears all control state and valid bits.
`timescale 1ns / 1ps
module actor_queue_scheduler_unit #(
   parameter int NUM_ACTORS    = aqs_pkg::ActorCount,
   parameter int QUEUE_DEPTH   = aqs_pkg::QueueDepth,
   parameter int PAYLOAD_WIDTH = aqs_pkg::PayloadBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [5:0]  req_actor_id,
   input  logic        req_held_valid,
   input  logic [31:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_grant_valid,
   output logic [5:0]  rsp_grant_actor,
   output logic [31:0] rsp_message,
   output logic        rsp_message_valid,
   output logic        rsp_error
);
   import aqs_pkg::*;

   cmd_type    cmd_data;
   result_type res;
   logic       cmd_valid, cmd_take;

   aqs_front #(.NUM_ACTORS(NUM_ACTORS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_kind, .req_actor_id,
      .req_held_valid, .req_payload, .cmd_valid, .cmd_take, .cmd_data);

   aqs_back #(.NUM_ACTORS(NUM_ACTORS), .QUEUE_DEPTH(QUEUE_DEPTH),
              .PAYLOAD_WIDTH(PAYLOAD_WIDTH)) u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_data,
      .rsp_valid, .rsp_stall, .rsp_data(res));

   assign rsp_grant_valid   = res.grant_valid;
   assign rsp_grant_actor   = res.grant_actor;
   assign rsp_message       = res.message;
   assign rsp_message_valid = res.message_valid;
   assign rsp_error         = res.error;

endmodule

/* rtl/aqs_front.sv */
// Front part: accepts items, classifies them and queues them for the back part.
`timescale 1ns / 1ps
module aqs_front #(
   parameter int NUM_ACTORS = aqs_pkg::ActorCount
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [aqs_pkg::KindBits-1:0] req_kind,
   input  logic [aqs_pkg::IdBits-1:0]   req_actor_id,
   input  logic                        req_held_valid,
   input  logic [31:0]                 req_payload,
   output logic                        cmd_valid,
   input  logic                        cmd_take,
   output aqs_pkg::cmd_type            cmd_data
);
   import aqs_pkg::*;

   // Two-entry command queue.
   cmd_type     slot_ff [2];
   cmd_type     slot_in;
   logic        rd_ptr_ff, wr_ptr_ff;
   logic [1:0]  count_ff;
   logic        push, pop;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_take && (count_ff != 2'd0);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = slot_ff[rd_ptr_ff];

   // Classify the item on the way in.
   always_comb begin
      slot_in.kind     = kind_type'(req_kind);
      slot_in.actor_id = req_actor_id;
      slot_in.in_range = ({26'd0, req_actor_id} < 32'(NUM_ACTORS));
      slot_in.held     = req_held_valid;
      slot_in.payload  = req_payload[PayloadBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   ap_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !push) else $error("queue overflow");
   ap_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0) else $error("queue underflow");
   ap_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("bad count");

endmodule

/* rtl/aqs_back.sv */
// Back part: per-actor FIFOs, active list and the fetch sequencer.
`timescale 1ns / 1ps
module aqs_back #(
   parameter int NUM_ACTORS    = aqs_pkg::ActorCount,
   parameter int QUEUE_DEPTH   = aqs_pkg::QueueDepth,
   parameter int PAYLOAD_WIDTH = aqs_pkg::PayloadBits
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_take,
   input  aqs_pkg::cmd_type     cmd_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output aqs_pkg::result_type  rsp_data
);
   import aqs_pkg::*;

   localparam int AW = (NUM_ACTORS > 1) ? $clog2(NUM_ACTORS) : 1;
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int LW = $clog2(NUM_ACTORS + 1);
   localparam int MW = AW + QW;
   localparam int SW = CW + 1;
   localparam int RW = LW + 1;
   localparam int MD = NUM_ACTORS * (1 << QW);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_EXEC  = 6'b000100,
      ST_RING  = 6'b001000,
      ST_CHECK = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   // Memories.
   logic [PAYLOAD_WIDTH-1:0] msg_mem [MD];
   logic [AW-1:0]            ring_mem [NUM_ACTORS];
   logic [QW-1:0]            head_mem [NUM_ACTORS];
   logic [CW-1:0]            cnt_mem  [NUM_ACTORS];
   logic [NUM_ACTORS-1:0]    meta_ok_ff;   // head/count valid bits
   logic [NUM_ACTORS-1:0]    listed_ff;

   state_type      state_ff;
   cmd_type        cmd_ff;
   logic [AW-1:0]  cur_ff;
   logic           have_ff;
   logic [QW-1:0]  head_rd_ff;
   logic [CW-1:0]  cnt_rd_ff;
   logic [AW-1:0]  ring_rd_ff;
   logic [PAYLOAD_WIDTH-1:0] msg_rd_ff;
   logic [AW-1:0]  ahead_ff;
   logic [LW-1:0]  acount_ff;
   result_type     res_ff;
   logic           out_valid_ff;

   logic [QW-1:0]  head_v;
   logic [CW-1:0]  cnt_v;
   logic [AW-1:0]  tail_idx;
   logic [AW-1:0]  next_head;
   logic [RW-1:0]  tail_sum;
   logic [SW-1:0]  slot_sum;
   logic [QW-1:0]  wr_off;
   logic [QW-1:0]  head_nx;

   assign head_v = meta_ok_ff[cur_ff] ? head_rd_ff : '0;
   assign cnt_v  = meta_ok_ff[cur_ff] ? cnt_rd_ff  : '0;

   // Ring positions wrap by compare and subtract.
   assign tail_sum  = RW'(ahead_ff) + RW'(acount_ff);
   assign tail_idx  = (tail_sum >= RW'(NUM_ACTORS)) ? AW'(tail_sum - RW'(NUM_ACTORS))
                                                    : AW'(tail_sum);
   assign next_head = (32'(ahead_ff) == NUM_ACTORS - 1) ? '0 : ahead_ff + AW'(1);

   // FIFO slot positions wrap the same way.
   assign slot_sum = SW'(head_v) + SW'(cnt_v);
   assign wr_off   = (slot_sum >= SW'(QUEUE_DEPTH)) ? QW'(slot_sum - SW'(QUEUE_DEPTH))
                                                    : QW'(slot_sum);
   assign head_nx  = (32'(head_v) == QUEUE_DEPTH - 1) ? '0 : head_v + QW'(1);

   assign cmd_take  = (state_ff == ST_IDLE) && !out_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = res_ff;

   logic [MW-1:0] wslot, rslot;
   assign wslot = {cur_ff, wr_off};
   assign rslot = {cur_ff, head_v};

   // Registered memory reads, addressed by the current actor; the ring read by its head.
   always_ff @(posedge clock) begin
      head_rd_ff <= head_mem[cur_ff];
      cnt_rd_ff  <= cnt_mem[cur_ff];
      ring_rd_ff <= ring_mem[ahead_ff];
      msg_rd_ff  <= msg_mem[rslot];
   end

   // Memory writes of the execute step.
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         if (cmd_ff.kind == KIND_PUSH && cmd_ff.in_range &&
             32'(cnt_v) < QUEUE_DEPTH) begin
            msg_mem[wslot] <= cmd_ff.payload[PAYLOAD_WIDTH-1:0];
            cnt_mem[cur_ff]  <= cnt_v + CW'(1);
            head_mem[cur_ff] <= head_v;
         end
         if (cmd_ff.kind == KIND_POP && cmd_ff.in_range && cnt_v != '0) begin
            cnt_mem[cur_ff]  <= cnt_v - CW'(1);
            head_mem[cur_ff] <= head_nx;
         end
      end
      if (state_ff == ST_EXEC && acount_ff != LW'(NUM_ACTORS) &&
          ((cmd_ff.kind == KIND_PUSH && cmd_ff.in_range && !listed_ff[cur_ff]) ||
           (cmd_ff.kind == KIND_FETCH && have_ff && acount_ff != '0))) begin
         ring_mem[tail_idx] <= cur_ff;
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         meta_ok_ff   <= '0;
         listed_ff    <= '0;
         ahead_ff     <= '0;
         acount_ff    <= '0;
         have_ff      <= 1'b0;
         cur_ff       <= '0;
      end else begin
         // The result register fills at the output step and empties once accepted.
         if (state_ff == ST_OUT) out_valid_ff <= 1'b1;
         else if (!rsp_stall) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid && cmd_take) begin
                  cmd_ff   <= cmd_data;
                  cur_ff   <= AW'(cmd_data.actor_id);
                  have_ff  <= cmd_data.held && cmd_data.in_range &&
                              (cmd_data.kind == KIND_FETCH);
                  res_ff   <= '0;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: state_ff <= ST_EXEC;
            ST_EXEC: begin
               case (cmd_ff.kind)
                  KIND_PUSH: begin
                     state_ff <= ST_OUT;
                     if (!cmd_ff.in_range) begin
                        res_ff.error <= 1'b1;
                     end else begin
                        if (!listed_ff[cur_ff] && acount_ff != LW'(NUM_ACTORS)) begin
                           acount_ff         <= acount_ff + LW'(1);
                           listed_ff[cur_ff] <= 1'b1;
                        end
                        if (32'(cnt_v) >= QUEUE_DEPTH) res_ff.error <= 1'b1;
                        else meta_ok_ff[cur_ff] <= 1'b1;
                     end
                  end
                  KIND_POP: begin
                     state_ff <= ST_OUT;
                     if (!cmd_ff.in_range || cnt_v == '0) begin
                        res_ff.error <= 1'b1;
                     end else begin
                        res_ff.message_valid <= 1'b1;
                     end
                  end
                  KIND_FETCH: begin
                     if (have_ff && acount_ff != '0) begin
                        if (acount_ff != LW'(NUM_ACTORS)) begin
                           acount_ff         <= acount_ff + LW'(1);
                           listed_ff[cur_ff] <= 1'b1;
                        end
                        have_ff <= 1'b0;
                     end
                     state_ff <= ST_CHECK;
                  end
                  default: begin
                     // A list entry re-enters CHECK through READ/EXEC with the no-op kind.
                     state_ff <= have_ff ? ST_CHECK : ST_OUT;
                  end
               endcase
            end
            ST_CHECK: begin
               // Grant the candidate if it has messages; else drop it and pop the next list entry.
               if (have_ff && cnt_v != '0) begin
                  res_ff.grant_valid <= 1'b1;
                  res_ff.grant_actor <= IdBits'(cur_ff);
                  state_ff <= ST_OUT;
               end else begin
                  if (have_ff) listed_ff[cur_ff] <= 1'b0;
                  if (acount_ff == '0) begin
                     state_ff <= ST_OUT;
                  end else begin
                     state_ff <= ST_RING;
                  end
               end
            end
            ST_RING: begin
               cur_ff    <= ring_rd_ff;
               have_ff   <= 1'b1;
               ahead_ff  <= next_head;
               acount_ff <= acount_ff - LW'(1);
               state_ff  <= ST_READ;
               cmd_ff.kind <= KIND_NOP;
            end
            ST_OUT: begin
               // The popped word is read during the execute step and is valid in the output state.
               if (cmd_ff.kind == KIND_POP && res_ff.message_valid)
                  res_ff.message <= MessageBits'(msg_rd_ff);
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   ap_count_bound: assert property (@(posedge clock) disable iff (reset)
      acount_ff <= LW'(NUM_ACTORS)) else $error("active count overflow");
   ap_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   ap_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> state_ff == ST_IDLE) else $error("take outside idle");
   ap_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(res_ff.grant_valid && res_ff.message_valid))
      else $error("grant and message together");

endmodule

/* tb/tb_actor_queue_scheduler_unit.sv */
// Testbench for the actor queue scheduler: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module tb_actor_queue_scheduler_unit;
   import aqs_pkg::*;

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles   = 300;
   localparam int ExpDepth      = 16;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [5:0]  req_actor_id;
   logic        req_held_valid;
   logic [31:0] req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_grant_valid;
   logic [5:0]  rsp_grant_actor;
   logic [31:0] rsp_message;
   logic        rsp_message_valid;
   logic        rsp_error;

   actor_queue_scheduler_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_actor_id(req_actor_id), .req_held_valid(req_held_valid),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_grant_valid(rsp_grant_valid), .rsp_grant_actor(rsp_grant_actor),
      .rsp_message(rsp_message), .rsp_message_valid(rsp_message_valid),
      .rsp_error(rsp_error)
   );

   // Scheduler state mirrored by the predictor.
   logic [MessageBits-1:0] msg_words [ActorCount*QueueDepth];
   int unsigned            q_head    [ActorCount];
   int unsigned            q_count   [ActorCount];
   bit                     on_list   [ActorCount];
   logic [IdBits-1:0]      ring      [ActorCount];
   int unsigned            ring_head;
   int unsigned            ring_count;

   // Expected results in order, kept in a small circular buffer.
   result_type  exp_results [ExpDepth];
   int unsigned exp_wr;
   int unsigned exp_rd;
   int          idle_pct;
   int          stall_pct;
   int          fail_count;
   int          items_sent;
   int          results_seen;
   int          grants_seen;
   int          errors_seen;
   int          quiet_cycles;
   logic [5:0]  last_granted;

   always #6 clock = ~clock;

   // Append an actor to the active ring unless the ring is full.
   function automatic void ring_append(logic [IdBits-1:0] actor);
      if (ring_count >= ActorCount) return;
      ring[(ring_head + ring_count) % ActorCount] = actor;
      ring_count++;
      on_list[actor] = 1'b1;
   endfunction

   // Work out the result of one accepted item and update the mirrored state.
   function automatic result_type schedule_step(kind_type kind, logic [5:0] actor,
                                                logic held, logic [31:0] word);
      result_type        r;
      bit                have;
      logic [IdBits-1:0] cur;
      int unsigned       slot;
      r = '0;
      case (kind)
         KIND_PUSH: begin
            if (!on_list[actor]) ring_append(actor);
            if (q_count[actor] >= QueueDepth) begin
               r.error = 1'b1;
            end else begin
               slot = (q_head[actor] + q_count[actor]) % QueueDepth;
               msg_words[actor*QueueDepth + slot] = word;
               q_count[actor]++;
            end
         end
         KIND_FETCH: begin
            have = held;
            cur  = actor;
            if (have && ring_count != 0) begin
               ring_append(cur);
               have = 1'b0;
            end
            // Drop empty actors from the head until one with messages is found.
            while (1) begin
               if (have && q_count[cur] != 0) begin
                  r.grant_valid = 1'b1;
                  r.grant_actor = cur;
                  break;
               end
               if (have) on_list[cur] = 1'b0;
               if (ring_count == 0) break;
               cur = ring[ring_head];
               ring_head = (ring_head + 1) % ActorCount;
               ring_count--;
               have = 1'b1;
            end
         end
         KIND_POP: begin
            if (q_count[actor] == 0) begin
               r.error = 1'b1;
            end else begin
               r.message       = msg_words[actor*QueueDepth + q_head[actor]];
               r.message_valid = 1'b1;
               q_head[actor]   = (q_head[actor] + 1) % QueueDepth;
               q_count[actor]--;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Offer one item, wait for acceptance, and record its expected result.
   task automatic send_item(kind_type kind, logic [5:0] actor, logic held,
                            logic [31:0] word);
      result_type r;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_actor_id   <= actor;
      req_held_valid <= held;
      req_payload    <= word;
      do @(posedge clock); while (req_stall);
      r = schedule_step(kind, actor, held, word);
      if (r.grant_valid) last_granted = r.grant_actor;
      exp_results[exp_wr % ExpDepth] = r;
      exp_wr++;
      items_sent++;
      @(negedge clock);
   endtask

   // Extremes of the fields, every operation, a full queue and an empty pop.
   task automatic test_directed();
      send_item(KIND_PUSH, 6'd63, 1'b0, 32'hFFFF_FFFF);
      for (int i = 0; i < QueueDepth; i++)
         send_item(KIND_PUSH, 6'd63, 1'b1, $urandom);
      send_item(KIND_PUSH, 6'd0, 1'b0, 32'h0000_0000);
      send_item(KIND_POP, 6'd63, 1'b0, 32'h0);
      send_item(KIND_POP, 6'd5, 1'b1, 32'hFFFF_FFFF);
      send_item(KIND_FETCH, 6'd0, 1'b0, 32'h0);
      send_item(KIND_FETCH, 6'd63, 1'b1, 32'h0);
      send_item(KIND_NOP, 6'd63, 1'b1, 32'hFFFF_FFFF);
      send_item(KIND_FETCH, 6'd7, 1'b1, 32'h0);
   endtask

   // Fill the active ring with every actor, then return held actors into it.
   task automatic test_ring_full();
      for (int a = 0; a < ActorCount; a++)
         send_item(KIND_PUSH, a[5:0], 1'b0, $urandom);
      for (int i = 0; i < 8; i++)
         send_item(KIND_FETCH, 6'($urandom_range(63)), 1'b1, $urandom);
      for (int i = 0; i < 40; i++)
         send_item(KIND_FETCH, last_granted, 1'($urandom_range(1)), 32'h0);
   endtask

   // Worker-like traffic on a few hot actors with some noise on all of them.
   task automatic test_random(int count, int idle, int stall);
      int          pick;
      logic [5:0]  actor;
      idle_pct  = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         pick  = $urandom_range(99);
         actor = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7));
         if (pick < 42)
            send_item(KIND_PUSH, actor, 1'($urandom_range(1)), $urandom);
         else if (pick < 70)
            send_item(KIND_FETCH, ($urandom_range(3) != 0) ? last_granted : actor,
                      $urandom_range(3) != 0, $urandom);
         else if (pick < 95)
            send_item(KIND_POP, ($urandom_range(1) != 0) ? last_granted : actor,
                      1'($urandom_range(1)), $urandom);
         else
            send_item(KIND_NOP, actor, 1'($urandom_range(1)), $urandom);
      end
   endtask

   // Random backpressure on the result channel.
   always @(negedge clock) begin
      if (!reset) rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic void check_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
         fail_count++;
      end
   endfunction

   // Compare each accepted result with the oldest expected one.
   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (exp_wr == exp_rd) begin
            $display("%0t: unexpected result, expected none, actual %0h", $time,
                     {rsp_grant_valid, rsp_grant_actor, rsp_message,
                      rsp_message_valid, rsp_error});
            fail_count++;
         end else begin
            exp_r = exp_results[exp_rd % ExpDepth];
            exp_rd++;
            if (exp_r.grant_valid) grants_seen++;
            if (exp_r.error) errors_seen++;
            check_field("grant_valid", 32'(exp_r.grant_valid), 32'(rsp_grant_valid));
            check_field("grant_actor", 32'(exp_r.grant_actor), 32'(rsp_grant_actor));
            check_field("message", exp_r.message, rsp_message);
            check_field("message_valid", 32'(exp_r.message_valid), 32'(rsp_message_valid));
            check_field("error", 32'(exp_r.error), 32'(rsp_error));
         end
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("actor_queue_scheduler_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = KIND_NOP;
      req_actor_id   = '0;
      req_held_valid = 1'b0;
      req_payload    = '0;
      rsp_stall      = 1'b0;
      idle_pct       = 0;
      stall_pct      = 0;
      fail_count     = 0;
      items_sent     = 0;
      results_seen   = 0;
      grants_seen    = 0;
      errors_seen    = 0;
      quiet_cycles   = 0;
      last_granted   = '0;
      exp_wr         = 0;
      exp_rd         = 0;
      ring_head      = 0;
      ring_count     = 0;
      for (int a = 0; a < ActorCount; a++) begin
         q_head[a]  = 0;
         q_count[a] = 0;
         on_list[a] = 1'b0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_ring_full();
      test_random(450, 0, 0);
      test_random(450, 64, 0);
      test_random(450, 0, 64);
      test_random(450, 29, 29);
      req_valid <= 1'b0;

      // Drain the remaining results, then let the block settle.
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d items across four idle and stall mixes; checked %0d results,",
               items_sent, results_seen);
      $display("of which %0d were grants and %0d reported errors.", grants_seen, errors_seen);
      if (fail_count == 0)
         $display("actor_queue_scheduler_unit verification clean");
      else
         $display("actor_queue_scheduler_unit verification failed");
      $finish;
   end

endmodule
